@@ src/icy_metadata_stream_demux_unit_assert.svh @@
// Assertion macros shared by the metadata stream demux RTL.
`ifndef ICY_METADATA_STREAM_DEMUX_UNIT_ASSERT_SVH
`define ICY_METADATA_STREAM_DEMUX_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imsd check failed in %m");

// The consequent must hold in the cycle after the antecedent.
`define IMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imsd check failed in %m");

`endif

@@ src/imsd_pkg.sv @@
// Shared types, constants and helpers of the metadata stream demux.
package imsd_pkg;

    localparam int INTERVAL_BITS = 20;
    localparam int WIDE_W        = INTERVAL_BITS + 4;
    localparam int IVL_OUT_W     = 20;
    localparam int META_CNT_W    = 12;
    localparam int KEY_LEN       = 12;
    localparam int KEY_POS_W     = 4;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = 2;
    localparam int FIFO_CW       = 3;

    typedef logic [INTERVAL_BITS-1:0] t_interval;
    localparam t_interval INTERVAL_MAX = '1;

    // Key positions for the partial-match fallback: a 'c' after "icy-metai"
    // continues as the "ic" of a new key.
    localparam logic [KEY_POS_W-1:0] KEY_POS_FALLBACK = 4'd9;
    localparam logic [KEY_POS_W-1:0] KEY_POS_IC       = 4'd2;
    localparam logic [KEY_POS_W-1:0] KEY_POS_I        = 4'd1;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LOW_I = 8'h69;
    localparam logic [7:0] CH_LOW_C = 8'h63;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_AUDIO_ONLY
    } t_phase;

    typedef enum logic [1:0] {
        KEY_SEARCH,
        KEY_VALUE,
        KEY_DONE
    } t_key_status;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_AUDIO    = 2'd1,
        KIND_META_LEN = 2'd2,
        KIND_META     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] lower;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_cr;
        logic       is_lf;
        logic       is_blank;
    } t_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h69; // i
            4'd1:    ch = 8'h63; // c
            4'd2:    ch = 8'h79; // y
            4'd3:    ch = 8'h2d; // -
            4'd4:    ch = 8'h6d; // m
            4'd5:    ch = 8'h65; // e
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h61; // a
            4'd8:    ch = 8'h69; // i
            4'd9:    ch = 8'h6e; // n
            4'd10:   ch = 8'h74; // t
            4'd11:   ch = 8'h3a; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ src/imsd_front.sv @@
// Front end: accepts input items and classifies each byte for the parser.
module imsd_front import imsd_pkg::*; (
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_cls       o_cls
);

    logic [7:0] digit_ofs;

    assign o_stall   = i_full;
    assign o_push    = i_valid && !i_full;
    assign digit_ofs = i_data_byte - CH_ZERO;

    always_comb begin
        o_cls.raw      = i_data_byte;
        o_cls.lower    = (i_data_byte >= CH_UP_A && i_data_byte <= CH_UP_Z)
                         ? i_data_byte + CASE_OFS : i_data_byte;
        o_cls.is_digit = (i_data_byte >= CH_ZERO && i_data_byte <= CH_NINE);
        o_cls.digit    = digit_ofs[3:0];
        o_cls.is_cr    = (i_data_byte == CH_CR);
        o_cls.is_lf    = (i_data_byte == CH_LF);
        o_cls.is_blank = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB);
    end

endmodule

@@ src/imsd_queue.sv @@
// Short queue of classified items between the front end and the parser.
module imsd_queue import imsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cls       i_cls,
    input  logic       i_pop,
    output t_cls       o_cls,
    output t_fifo_stat o_stat
);

    t_cls               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_CW-1:0] r_count;

    assign o_cls        = r_mem[r_rd];
    assign o_stat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

endmodule

@@ src/imsd_back.sv @@
// Back end: header parser, audio/metadata tagger and output register.
module imsd_back import imsd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cls                 i_cls,
    input  logic                 i_avail,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [1:0]           o_byte_kind,
    output logic [7:0]           o_byte_value,
    output logic                 o_block_last,
    output logic                 o_interval_error,
    output logic [IVL_OUT_W-1:0] o_interval_value
);

    t_phase                r_phase, n_phase;
    logic [1:0]            r_term, n_term;
    logic [KEY_POS_W-1:0]  r_key_pos, n_key_pos;
    t_key_status           r_key_st, n_key_st;
    t_interval             r_mi, n_mi;
    t_interval             r_ac, n_ac;
    logic [META_CNT_W-1:0] r_ms, n_ms;

    logic                  r_out_valid;
    t_kind                 r_kind, n_kind;
    logic [7:0]            r_byte;
    logic                  r_last, n_last;
    logic                  r_err, n_err;
    logic [IVL_OUT_W-1:0]  r_ivl, n_ivl;

    logic [WIDE_W-1:0]     mi_wide;
    t_interval             mi_sat;
    logic                  term_hit;
    logic [INTERVAL_BITS+IVL_OUT_W-1:0] cur_ext, nxt_ext;

    assign o_pop    = i_avail && (!r_out_valid || !i_stall);
    assign term_hit = i_cls.is_lf && (r_term == 2'd3);

    // Interval times ten plus the new digit, saturating.
    assign mi_wide = (WIDE_W'(r_mi) << 3) + (WIDE_W'(r_mi) << 1) + WIDE_W'(i_cls.digit);
    assign mi_sat  = (|mi_wide[WIDE_W-1:INTERVAL_BITS]) ? INTERVAL_MAX
                                                       : mi_wide[INTERVAL_BITS-1:0];

    assign cur_ext = {{IVL_OUT_W{1'b0}}, r_mi};
    assign nxt_ext = {{IVL_OUT_W{1'b0}}, n_mi};

    // Next state.
    always_comb begin
        n_phase   = r_phase;
        n_term    = r_term;
        n_key_pos = r_key_pos;
        n_key_st  = r_key_st;
        n_mi      = r_mi;
        n_ac      = r_ac;
        n_ms      = r_ms;
        if (o_pop) begin
            unique case (r_phase)
                PH_DATA: begin
                    if (r_ms != '0) begin
                        n_ms = r_ms - META_CNT_W'(1);
                    end else if (r_ac >= r_mi) begin
                        n_ac = '0;
                        n_ms = META_CNT_W'({i_cls.raw, 4'b0000});
                    end else begin
                        n_ac = r_ac + INTERVAL_BITS'(1);
                    end
                end
                PH_AUDIO_ONLY: begin
                end
                default: begin
                    if (r_key_st == KEY_SEARCH) begin
                        if (i_cls.lower == key_char(r_key_pos)) begin
                            if (r_key_pos == KEY_POS_W'(KEY_LEN - 1)) begin
                                n_key_st  = KEY_VALUE;
                                n_key_pos = '0;
                            end else begin
                                n_key_pos = r_key_pos + KEY_POS_W'(1);
                            end
                        end else if (r_key_pos == KEY_POS_FALLBACK &&
                                     i_cls.lower == CH_LOW_C) begin
                            n_key_pos = KEY_POS_IC;
                        end else if (i_cls.lower == CH_LOW_I) begin
                            n_key_pos = KEY_POS_I;
                        end else begin
                            n_key_pos = '0;
                        end
                    end else if (r_key_st == KEY_VALUE) begin
                        if (i_cls.is_digit) begin
                            n_mi = mi_sat;
                        end else if (i_cls.is_cr) begin
                            n_key_st = KEY_DONE;
                        end else if (!i_cls.is_blank) begin
                            n_mi     = '0;
                            n_key_st = KEY_DONE;
                        end
                    end

                    if (i_cls.is_cr) begin
                        n_term = (r_term == 2'd2) ? 2'd3 : 2'd1;
                    end else if (i_cls.is_lf && (r_term == 2'd1 || r_term == 2'd3)) begin
                        n_term = r_term + 2'd1;
                    end else begin
                        n_term = 2'd0;
                    end

                    if (term_hit) begin
                        n_term  = 2'd0;
                        n_ac    = '0;
                        n_ms    = '0;
                        n_phase = (n_mi == '0) ? PH_AUDIO_ONLY : PH_DATA;
                    end
                end
            endcase
        end
    end

    // Result fields of the item being taken.
    always_comb begin
        n_kind = KIND_AUDIO;
        n_last = 1'b0;
        n_err  = 1'b0;
        n_ivl  = cur_ext[IVL_OUT_W-1:0];
        unique case (r_phase)
            PH_DATA: begin
                if (r_ms != '0) begin
                    n_kind = KIND_META;
                    n_last = (r_ms == META_CNT_W'(1));
                end else if (r_ac >= r_mi) begin
                    n_kind = KIND_META_LEN;
                end
            end
            PH_AUDIO_ONLY: begin
                n_err = 1'b1;
            end
            default: begin
                n_kind = KIND_HEADER;
                n_last = term_hit;
                n_err  = term_hit && (n_mi == '0);
                n_ivl  = term_hit ? nxt_ext[IVL_OUT_W-1:0] : '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_term      <= '0;
            r_key_pos   <= '0;
            r_key_st    <= KEY_SEARCH;
            r_mi        <= '0;
            r_ac        <= '0;
            r_ms        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_term    <= n_term;
            r_key_pos <= n_key_pos;
            r_key_st  <= n_key_st;
            r_mi      <= n_mi;
            r_ac      <= n_ac;
            r_ms      <= n_ms;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
            r_byte <= i_cls.raw;
            r_last <= n_last;
            r_err  <= n_err;
            r_ivl  <= n_ivl;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_byte_kind      = r_kind;
    assign o_byte_value     = r_byte;
    assign o_block_last     = r_last;
    assign o_interval_error = r_err;
    assign o_interval_value = r_ivl;

endmodule

@@ src/icy_metadata_stream_demux_unit.sv @@
// Top level of the streaming radio response byte tagger.
// An accepted item enters the queue, then the output register once the output is not stalled.
// Throughput: one item per cycle while not stalled; the parser handles one byte per cycle.
// A four-entry queue lets the input keep taking items while the output is stalled.
// Reset: synchronous, active low; clears the parser state, the queue and output valid.
module icy_metadata_stream_demux_unit import imsd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_byte_kind,
    output logic [7:0]           o_byte_value,
    output logic                 o_block_last,
    output logic                 o_interval_error,
    output logic [IVL_OUT_W-1:0] o_interval_value
);

`include "icy_metadata_stream_demux_unit_assert.svh"

    t_cls       push_cls;
    t_cls       head_cls;
    t_fifo_stat q_stat;
    logic       push;
    logic       pop;

    imsd_front u_front (
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_full      (q_stat.full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_cls       (push_cls)
    );

    imsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (push_cls),
        .i_pop   (pop),
        .o_cls   (head_cls),
        .o_stat  (q_stat)
    );

    imsd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cls            (head_cls),
        .i_avail          (!q_stat.empty),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_byte_kind      (o_byte_kind),
        .o_byte_value     (o_byte_value),
        .o_block_last     (o_block_last),
        .o_interval_error (o_interval_error),
        .o_interval_value (o_interval_value)
    );

    // Header bytes before the terminator carry no interval information.
    `IMSD_ASSERT_SAME(a_header_no_interval, i_clk, i_rst_n, o_valid && o_byte_kind == KIND_HEADER && !o_block_last, o_interval_value == '0 && !o_interval_error)
    // The error flag shows only on the final header byte or on audio bytes.
    `IMSD_ASSERT_SAME(a_error_kind, i_clk, i_rst_n, o_valid && o_interval_error, o_byte_kind == KIND_AUDIO || (o_byte_kind == KIND_HEADER && o_block_last))
    // An accepted item is held in the queue on the next cycle.
    `IMSD_ASSERT_NEXT(a_push_not_lost, i_clk, i_rst_n, i_valid && !o_stall, !q_stat.empty)

endmodule

@@ tb/sv/imsd_tag_checker.sv @@
// Checker for the byte tagger: predicts each tag from the accepted input items and compares.
module imsd_tag_checker import imsd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [1:0]           i_byte_kind,
    input  logic [7:0]           i_byte_value,
    input  logic                 i_block_last,
    input  logic                 i_interval_error,
    input  logic [IVL_OUT_W-1:0] i_interval_value,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int KEY_CHARS = 12;
    localparam logic [8*KEY_CHARS-1:0] KEY_TEXT = "icy-metaint:";

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           value;
        logic                 last;
        logic                 err;
        logic [IVL_OUT_W-1:0] ivl;
    } t_byte_tag;

    t_byte_tag   tags_due[$];
    int          fail_total = 0;
    int          waiting = 0;

    // Parser state of the prediction, starting from its reset values.
    t_phase      ph = PH_HEADER;
    logic [2:0]  crlf_run = '0;
    logic [3:0]  key_pos = '0;
    t_key_status key_st = KEY_SEARCH;
    t_interval   interval_acc = '0;
    t_interval   audio_run = '0;
    logic [11:0] meta_left = '0;

    assign o_fail_count = fail_total;
    assign o_pending    = waiting;

    function automatic t_byte_tag tag_next_byte(input logic [7:0] b);
        t_byte_tag  r;
        logic [7:0] lc;
        logic [63:0] grown;
        int         kp;
        r.kind  = KIND_AUDIO;
        r.value = b;
        r.last  = 1'b0;
        r.err   = 1'b0;
        r.ivl   = '0;
        lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
        kp = key_pos;
        case (ph)
            PH_HEADER: begin
                r.kind = KIND_HEADER;
                if (key_st == KEY_SEARCH) begin
                    if (kp < KEY_CHARS && lc == KEY_TEXT[8*(KEY_CHARS-1-kp) +: 8]) begin
                        if (kp == KEY_CHARS - 1) begin
                            key_st  = KEY_VALUE;
                            key_pos = '0;
                        end else begin
                            key_pos = key_pos + 1'b1;
                        end
                    // A 'c' after "icy-metai" restarts as the "ic" of a fresh key.
                    end else if (kp == 9 && lc == CH_LOW_C) begin
                        key_pos = 4'd2;
                    end else if (lc == CH_LOW_I) begin
                        key_pos = 4'd1;
                    end else begin
                        key_pos = '0;
                    end
                end else if (key_st == KEY_VALUE) begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        grown = interval_acc;
                        grown = grown * 10 + (b - CH_ZERO);
                        interval_acc = (grown > INTERVAL_MAX) ? INTERVAL_MAX : grown;
                    end else if (b == CH_CR) begin
                        key_st = KEY_DONE;
                    end else if (b != CH_SPACE && b != CH_TAB) begin
                        interval_acc = '0;
                        key_st       = KEY_DONE;
                    end
                end
                if (b == CH_CR)
                    crlf_run = (crlf_run == 3'd2) ? 3'd3 : 3'd1;
                else if (b == CH_LF && (crlf_run == 3'd1 || crlf_run == 3'd3))
                    crlf_run = crlf_run + 1'b1;
                else
                    crlf_run = '0;
                if (crlf_run == 3'd4) begin
                    r.last    = 1'b1;
                    crlf_run  = '0;
                    audio_run = '0;
                    meta_left = '0;
                    ph        = (interval_acc == '0) ? PH_AUDIO_ONLY : PH_DATA;
                    r.err     = (interval_acc == '0);
                    r.ivl     = interval_acc;
                end
            end
            PH_AUDIO_ONLY: begin
                r.err = 1'b1;
                r.ivl = interval_acc;
            end
            default: begin
                r.ivl = interval_acc;
                if (meta_left != '0) begin
                    r.kind    = KIND_META;
                    meta_left = meta_left - 1'b1;
                    r.last    = (meta_left == '0);
                end else if (audio_run >= interval_acc) begin
                    r.kind    = KIND_META_LEN;
                    audio_run = '0;
                    meta_left = {b, 4'b0000};
                end else begin
                    audio_run = audio_run + 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_byte_tag want_tag;
        if (i_rst_n) begin
            // Compare first: a result leaving at this edge belongs to an older item.
            if (i_out_valid && !i_out_stall) begin
                if (tags_due.size() == 0) begin
                    $error("unexpected result: kind %0d, value 0x%0h", i_byte_kind, i_byte_value);
                    fail_total++;
                end else begin
                    want_tag = tags_due.pop_front();
                    check_field("byte_kind", want_tag.kind, i_byte_kind);
                    check_field("byte_value", want_tag.value, i_byte_value);
                    check_field("block_last", want_tag.last, i_block_last);
                    check_field("interval_error", want_tag.err, i_interval_error);
                    check_field("interval_value", want_tag.ivl, i_interval_value);
                end
            end
            if (i_in_valid && !i_in_stall)
                tags_due.push_back(tag_next_byte(i_in_byte));
            waiting <= tags_due.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: feeds the tagger a generated radio response and reports the verdict.
module tb;
    import imsd_pkg::*;

    localparam int ITEM_TARGET    = 1650;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int BIG_BLOCK_ROOM = 300;

    typedef enum int {
        PLAN_NORMAL,
        PLAN_BAD_VALUE,
        PLAN_ZERO_VALUE,
        PLAN_SATURATE
    } t_plan;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [7:0]           i_data_byte = '0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [1:0]           o_byte_kind;
    logic [7:0]           o_byte_value;
    logic                 o_block_last;
    logic                 o_interval_error;
    logic [IVL_OUT_W-1:0] o_interval_value;

    int    fail_count;
    int    pending;
    int    items_sent = 0;
    bit    calm = 1'b0;
    int    rx_wait = 0;
    logic  rx_took = 1'b0;
    int    idle_cycles = 0;
    t_plan plan;
    int    interval_len;
    int    block_idx;
    int    meta_len;
    int    room;

    always #5 i_clk = ~i_clk;

    icy_metadata_stream_demux_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_byte_kind      (o_byte_kind),
        .o_byte_value     (o_byte_value),
        .o_block_last     (o_block_last),
        .o_interval_error (o_interval_error),
        .o_interval_value (o_interval_value)
    );

    imsd_tag_checker tag_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_byte        (i_data_byte),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_byte_kind      (o_byte_kind),
        .i_byte_value     (o_byte_value),
        .i_block_last     (o_block_last),
        .i_interval_error (o_interval_error),
        .i_interval_value (o_interval_value),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    function automatic int pick_wait();
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // The receiver holds stall for a freshly drawn number of cycles after each item.
    always @(posedge i_clk)
        rx_took <= o_valid && !i_stall;

    always @(negedge i_clk) begin
        if (rx_took)
            rx_wait = pick_wait();
        if (rx_wait != 0) begin
            i_stall <= 1'b1;
            rx_wait = rx_wait - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (items_sent % 150 == 0)
            calm = ($urandom_range(0, 3) == 0);
        gap = pick_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_noise_line();
        logic [7:0] b;
        int         n;
        n = $urandom_range(1, 16);
        repeat (n) begin
            b = $urandom_range(0, 255);
            // Keep line breaks out so the header cannot end early.
            if (b == CH_CR || b == CH_LF)
                b = b | 8'h80;
            send_byte(b);
        end
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_byte($urandom_range(0, 255));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        case ($urandom_range(0, 9))
            0:       plan = PLAN_BAD_VALUE;
            1:       plan = PLAN_ZERO_VALUE;
            2:       plan = PLAN_SATURATE;
            default: plan = PLAN_NORMAL;
        endcase
        interval_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);

        // Header with partial keys, a mixed-case key that needs the "ic" restart,
        // a lone CR inside a line and a second key that must be ignored.
        send_line("ICY 200 OK");
        send_line("icy-name:iicy-meta Icy-metaX");
        send_noise_line();
        send_byte(CH_UP_A);
        send_byte(CH_CR);
        send_line("");
        send_text("Icy-MetaIcy-metaINT:");
        case (plan)
            PLAN_BAD_VALUE:  send_line(" 12x4");
            PLAN_ZERO_VALUE: send_line("\t000 ");
            PLAN_SATURATE:   send_line("99999999999");
            default: begin
                send_text(" \t0");
                send_line($sformatf("%0d ", interval_len));
            end
        endcase
        send_line("icy-metaint:5");
        send_noise_line();
        send_line("");
        wait_drained();

        block_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (plan != PLAN_NORMAL) begin
                send_random(64);
            end else begin
                send_random(interval_len);
                // The largest block comes last and is cut off where the run ends.
                if (ITEM_TARGET - items_sent <= BIG_BLOCK_ROOM)
                    meta_len = 255;
                else if ($urandom_range(0, 7) == 0)
                    meta_len = $urandom_range(4, 16);
                else
                    meta_len = $urandom_range(0, 3);
                send_byte(8'(meta_len));
                room = ITEM_TARGET - items_sent;
                if (room < 0)
                    room = 0;
                send_random((room < meta_len * 16) ? room : meta_len * 16);
            end
            if (block_idx == 6)
                wait_drained();
            block_idx++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
